### sv/sine_tone_sample_generator_defines.svh
// ----------------------------------------------------------------------------
// Sine tone sample generator assertion macros
// Shared property shorthands; clk and rst_n must be in scope at the use site.
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_SAMPLE_GENERATOR_DEFINES_SVH
`define SINE_TONE_SAMPLE_GENERATOR_DEFINES_SVH

// same-cycle implication
`define STS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// Sine tone sample generator package
// Widths, codes, shared types and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int RATE_W           = 19;
    localparam int LOOP_W           = 24;
    localparam int CHCFG_W          = 4;
    localparam int FMT_W            = 3;
    localparam int FRAME_COUNT_BITS = 24;
    localparam int MAX_CHANNELS     = 8;
    localparam int CHAN_W           = 3;
    localparam int CHAN_CNT_W       = $clog2(MAX_CHANNELS + 1);
    localparam int SAMPLE_W         = 32;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 24;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int QUARTER_LEN      = SINE_TABLE_DEPTH / 4;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_W            = $clog2(QUARTER_LEN);
    localparam int QADDR_W          = $clog2(QUARTER_LEN + 1);
    localparam int Q15_W            = 16;
    localparam int MAG_W            = 15;

    localparam int DVD_W            = 2 * RATE_W;
    localparam int STEP_W           = $clog2(DVD_W + 1);
    localparam int POS_CMP_W        = (FRAME_COUNT_BITS > LOOP_W) ? FRAME_COUNT_BITS : LOOP_W;

    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 10;
    localparam longint unsigned TAYLOR_DIV [1:TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    typedef enum logic [FMT_W-1:0] {
        FMT_U8  = 3'd0,
        FMT_S8  = 3'd1,
        FMT_U16 = 3'd2,
        FMT_S16 = 3'd3,
        FMT_F32 = 3'd4
    } sample_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE    = 3'd0,
        REG_TONE_FREQUENCY = 3'd1,
        REG_CHANNEL_COUNT  = 3'd2,
        REG_SAMPLE_FORMAT  = 3'd3,
        REG_BIG_ENDIAN     = 3'd4,
        REG_LOOP_FRAMES    = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MOD_POS,
        BK_MUL,
        BK_MOD_PHASE,
        BK_IDX_START,
        BK_INDEX,
        BK_LOOKUP,
        BK_FORMAT,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [RATE_W-1:0]  sample_rate;
        logic [RATE_W-1:0]  tone_frequency;
        logic [CHCFG_W-1:0] channel_count;
        logic [FMT_W-1:0]   sample_format;
        logic               big_endian;
        logic [LOOP_W-1:0]  loop_frames;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [RATE_W-1:0]  divisor;
        logic [RATE_W-1:0]  rem_init;
        logic [DVD_W-1:0]   dividend;
        logic [STEP_W-1:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DVD_W-1:0]   quotient;
        logic [RATE_W-1:0]  remainder;
    } div_rsp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [Q15_W-1:0] quarter_sine(input int unsigned k);
        longint unsigned th;
        longint unsigned th2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned q;
        int              n;
        th   = (HALF_PI_Q30 * 64'(k)) / QUARTER_LEN;
        th2  = (th * th) >> 30;
        term = th;
        sum  = th;
        for (n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = (term * th2) >> 30;
            term = term / TAYLOR_DIV[n];
            if ((n & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        q = (sum + 64'd16384) >> 15;
        if (q > 64'd32767)
            q = 64'd32767;
        return q[Q15_W-1:0];
    endfunction

    function automatic logic [CHAN_CNT_W-1:0] clamp_channels(input logic [CHCFG_W-1:0] cc);
        logic [CHAN_CNT_W-1:0] res;
        if (cc == '0)
            res = CHAN_CNT_W'(1);
        else if (32'(cc) > MAX_CHANNELS)
            res = CHAN_CNT_W'(MAX_CHANNELS);
        else
            res = CHAN_CNT_W'(cc);
        return res;
    endfunction

endpackage

### sv/sts_queue.sv
// ----------------------------------------------------------------------------
// Frame position queue
// Short FIFO of frame positions between the request front and the sample back.
// ----------------------------------------------------------------------------
module sts_queue (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [sts_pkg::FRAME_COUNT_BITS-1:0] push_data,
    input  logic                                 pop,
    output logic [sts_pkg::FRAME_COUNT_BITS-1:0] pop_data,
    output sts_pkg::q_stat_t                     stat
);

    logic [sts_pkg::FRAME_COUNT_BITS-1:0] entry_reg [0:sts_pkg::QUEUE_DEPTH-1];
    logic [sts_pkg::QPTR_W-1:0]           wr_ptr_reg;
    logic [sts_pkg::QPTR_W-1:0]           rd_ptr_reg;
    logic [sts_pkg::QCNT_W-1:0]           count_reg;
    logic [sts_pkg::QPTR_W-1:0]           wr_ptr_next;
    logic [sts_pkg::QPTR_W-1:0]           rd_ptr_next;

    assign wr_ptr_next = (32'(wr_ptr_reg) == sts_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (32'(rd_ptr_reg) == sts_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;

    assign pop_data   = entry_reg[rd_ptr_reg];
    assign stat.full  = (32'(count_reg) == sts_pkg::QUEUE_DEPTH);
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### sv/sts_front.sv
// ----------------------------------------------------------------------------
// Request front end
// Take request words, apply restart, advance and wrap the frame position.
// ----------------------------------------------------------------------------
module sts_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 frame_request,
    input  logic                                 restart,
    input  logic [sts_pkg::LOOP_W-1:0]           loop_frames,
    input  sts_pkg::q_stat_t                     q_stat,
    output logic                                 push,
    output logic [sts_pkg::FRAME_COUNT_BITS-1:0] push_pos
);

    logic [sts_pkg::FRAME_COUNT_BITS-1:0] pos_reg;
    logic [sts_pkg::FRAME_COUNT_BITS-1:0] pos_next;
    logic [sts_pkg::FRAME_COUNT_BITS-1:0] pos_used;
    logic [sts_pkg::FRAME_COUNT_BITS-1:0] pos_inc;
    logic [sts_pkg::LOOP_W-1:0]           loop_eff;
    logic                                 accept;
    logic                                 wrap;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign pos_used = restart ? '0 : pos_reg;
    assign pos_inc  = pos_used + 1'b1;
    assign loop_eff = (loop_frames == '0) ? sts_pkg::LOOP_W'(1) : loop_frames;
    assign wrap     = sts_pkg::POS_CMP_W'(pos_inc) >= sts_pkg::POS_CMP_W'(loop_eff);
    assign pos_next = frame_request ? (wrap ? '0 : pos_inc) : pos_used;
    assign push     = accept && frame_request;
    assign push_pos = pos_used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (accept)
            pos_reg <= pos_next;
    end

endmodule

### sv/sts_divider.sv
// ----------------------------------------------------------------------------
// Shared bit-serial divider
// Restoring division, one quotient bit per cycle, remainder may be preloaded.
// ----------------------------------------------------------------------------
module sts_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  sts_pkg::div_req_t   req,
    output sts_pkg::div_rsp_t   rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [sts_pkg::STEP_W-1:0]    cnt_reg;
    logic [sts_pkg::DVD_W-1:0]     dvd_reg;
    logic [sts_pkg::RATE_W-1:0]    rem_reg;
    logic [sts_pkg::RATE_W-1:0]    dsr_reg;
    logic [sts_pkg::RATE_W:0]      rem_sh;
    logic [sts_pkg::RATE_W:0]      rem_sub;
    logic                          fits;
    logic [sts_pkg::RATE_W-1:0]    rem_next;
    logic [sts_pkg::DVD_W-1:0]     dvd_next;

    assign rem_sh   = {rem_reg, dvd_reg[sts_pkg::DVD_W-1]};
    assign fits     = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub  = rem_sh - {1'b0, dsr_reg};
    assign rem_next = fits ? rem_sub[sts_pkg::RATE_W-1:0] : rem_sh[sts_pkg::RATE_W-1:0];
    assign dvd_next = {dvd_reg[sts_pkg::DVD_W-2:0], fits};

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == sts_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= req.rem_init;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

endmodule

### sv/sts_back.sv
// ----------------------------------------------------------------------------
// Sample back end
// Phase arithmetic, quarter-wave lookup, PCM formatting and channel emission.
// ----------------------------------------------------------------------------
module sts_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sts_pkg::cfg_t                        cfg,
    input  sts_pkg::q_stat_t                     q_stat,
    output logic                                 pop,
    input  logic [sts_pkg::FRAME_COUNT_BITS-1:0] pop_pos,
    output sts_pkg::div_req_t                    div_req,
    input  sts_pkg::div_rsp_t                    div_rsp,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sts_pkg::SAMPLE_W-1:0]         sample_word,
    output logic [sts_pkg::CHAN_W-1:0]           channel_index,
    output logic                                 last
);

    sts_pkg::back_state_t state_reg;
    sts_pkg::back_state_t state_next;

    logic [sts_pkg::Q15_W-1:0]      sine_tab [0:sts_pkg::QUARTER_LEN];

    logic [sts_pkg::RATE_W-1:0]     sr_eff;
    logic [sts_pkg::RATE_W-1:0]     a_reg;
    logic [sts_pkg::RATE_W-1:0]     ph_reg;
    logic [sts_pkg::IDX_W-1:0]      idx_reg;
    logic [sts_pkg::MAG_W-1:0]      mag_reg;
    logic [sts_pkg::SAMPLE_W-1:0]   word_reg;
    logic [sts_pkg::CHAN_CNT_W-1:0] chans_reg;
    logic [sts_pkg::CHAN_CNT_W-1:0] ch_reg;
    logic                           out_valid_reg;
    logic [sts_pkg::SAMPLE_W-1:0]   sample_word_reg;
    logic [sts_pkg::CHAN_W-1:0]     channel_index_reg;
    logic                           last_reg;

    logic [sts_pkg::DVD_W-1:0]      product;
    logic [sts_pkg::QTR_W-1:0]      tab_r;
    logic [sts_pkg::QADDR_W-1:0]    tab_addr;
    logic                           emit_load;
    logic                           emit_last;

    logic                           neg;
    logic [16:0]                    biased;
    logic [24:0]                    u8_prod;
    logic [21:0]                    s8_prod;
    logic [32:0]                    u16_prod;
    logic [29:0]                    s16_prod;
    logic [7:0]                     s8_word;
    logic [15:0]                    s16_word;
    logic [3:0]                     lead;
    logic [23:0]                    mant_sh;
    logic [sts_pkg::SAMPLE_W-1:0]   f32_word;
    logic [sts_pkg::SAMPLE_W-1:0]   fmt_word;

    for (genvar k = 0; k <= sts_pkg::QUARTER_LEN; k++)
    begin : g_tab
        localparam logic [sts_pkg::Q15_W-1:0] ENTRY = sts_pkg::quarter_sine(k);
        assign sine_tab[k] = ENTRY;
    end

    assign sr_eff   = (cfg.sample_rate == '0) ? sts_pkg::RATE_W'(1) : cfg.sample_rate;
    assign product  = {{sts_pkg::RATE_W{1'b0}}, cfg.tone_frequency}
                    * {{sts_pkg::RATE_W{1'b0}}, a_reg};
    assign tab_r    = idx_reg[sts_pkg::QTR_W-1:0];
    assign tab_addr = idx_reg[sts_pkg::QTR_W]
                    ? sts_pkg::QADDR_W'(sts_pkg::QUARTER_LEN) - sts_pkg::QADDR_W'(tab_r)
                    : sts_pkg::QADDR_W'(tab_r);

    assign emit_load = (state_reg == sts_pkg::BK_EMIT) && (!out_valid_reg || out_ready);
    assign emit_last = (ch_reg + sts_pkg::CHAN_CNT_W'(1)) == chans_reg;

    // format conversion, truncating toward zero
    always_comb
    begin
        neg      = idx_reg[sts_pkg::IDX_W-1] && (mag_reg != '0);
        biased   = neg ? (17'd32768 - {2'b0, mag_reg}) : (17'd32768 + {2'b0, mag_reg});
        u8_prod  = {biased, 8'b0} - {8'b0, biased};
        s8_prod  = 22'(mag_reg) * 22'd127;
        u16_prod = {biased, 16'b0} - {16'b0, biased};
        s16_prod = 30'(mag_reg) * 30'd32767;
        s8_word  = neg ? (8'd0 - {1'b0, s8_prod[21:15]}) : {1'b0, s8_prod[21:15]};
        s16_word = neg ? (16'd0 - {1'b0, s16_prod[29:15]}) : {1'b0, s16_prod[29:15]};
        lead     = 4'd0;
        for (int i = 0; i < sts_pkg::MAG_W; i++)
        begin
            if (mag_reg[i])
                lead = 4'(i);
        end
        mant_sh  = {9'b0, mag_reg} << (5'd23 - {1'b0, lead});
        f32_word = (mag_reg == '0) ? '0
                 : {neg, 8'd112 + {4'b0, lead}, mant_sh[22:0]};
        case (sts_pkg::sample_fmt_t'(cfg.sample_format))
            sts_pkg::FMT_U8:
                fmt_word = {24'b0, u8_prod[23:16]};
            sts_pkg::FMT_S8:
                fmt_word = {24'b0, s8_word};
            sts_pkg::FMT_U16:
                fmt_word = cfg.big_endian ? {16'b0, u16_prod[23:16], u16_prod[31:24]}
                                          : {16'b0, u16_prod[31:16]};
            sts_pkg::FMT_S16:
                fmt_word = cfg.big_endian ? {16'b0, s16_word[7:0], s16_word[15:8]}
                                          : {16'b0, s16_word};
            sts_pkg::FMT_F32:
                fmt_word = cfg.big_endian ? {f32_word[7:0], f32_word[15:8],
                                             f32_word[23:16], f32_word[31:24]}
                                          : f32_word;
            default:
                fmt_word = '0;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        pop              = 1'b0;
        div_req          = '0;
        div_req.divisor  = sr_eff;
        case (state_reg)
            sts_pkg::BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop              = 1'b1;
                    div_req.start    = 1'b1;
                    div_req.dividend = {pop_pos,
                                        {(sts_pkg::DVD_W - sts_pkg::FRAME_COUNT_BITS){1'b0}}};
                    div_req.steps    = sts_pkg::STEP_W'(sts_pkg::FRAME_COUNT_BITS);
                    state_next       = sts_pkg::BK_MOD_POS;
                end
            end
            sts_pkg::BK_MOD_POS:
            begin
                if (div_rsp.done)
                    state_next = sts_pkg::BK_MUL;
            end
            sts_pkg::BK_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = product;
                div_req.steps    = sts_pkg::STEP_W'(sts_pkg::DVD_W);
                state_next       = sts_pkg::BK_MOD_PHASE;
            end
            sts_pkg::BK_MOD_PHASE:
            begin
                if (div_rsp.done)
                    state_next = sts_pkg::BK_IDX_START;
            end
            sts_pkg::BK_IDX_START:
            begin
                div_req.start    = 1'b1;
                div_req.rem_init = ph_reg;
                div_req.steps    = sts_pkg::STEP_W'(sts_pkg::IDX_W);
                state_next       = sts_pkg::BK_INDEX;
            end
            sts_pkg::BK_INDEX:
            begin
                if (div_rsp.done)
                    state_next = sts_pkg::BK_LOOKUP;
            end
            sts_pkg::BK_LOOKUP:
                state_next = sts_pkg::BK_FORMAT;
            sts_pkg::BK_FORMAT:
                state_next = sts_pkg::BK_EMIT;
            sts_pkg::BK_EMIT:
            begin
                if (emit_load && emit_last)
                    state_next = sts_pkg::BK_IDLE;
            end
            default:
                state_next = sts_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sts_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == sts_pkg::BK_MOD_PHASE && div_rsp.done)
                ph_reg <= div_rsp.remainder;
            if (state_reg == sts_pkg::BK_FORMAT)
                ch_reg <= '0;
            else if (emit_load)
                ch_reg <= ch_reg + 1'b1;
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sts_pkg::BK_MOD_POS && div_rsp.done)
            a_reg <= div_rsp.remainder;
        if (state_reg == sts_pkg::BK_INDEX && div_rsp.done)
            idx_reg <= div_rsp.quotient[sts_pkg::IDX_W-1:0];
        if (state_reg == sts_pkg::BK_LOOKUP)
            mag_reg <= sine_tab[tab_addr][sts_pkg::MAG_W-1:0];
        if (state_reg == sts_pkg::BK_FORMAT)
        begin
            word_reg  <= fmt_word;
            chans_reg <= sts_pkg::clamp_channels(cfg.channel_count);
        end
        if (emit_load)
        begin
            sample_word_reg   <= word_reg;
            channel_index_reg <= sts_pkg::CHAN_W'(ch_reg);
            last_reg          <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_word   = sample_word_reg;
    assign channel_index = channel_index_reg;
    assign last          = last_reg;

endmodule

### sv/sine_tone_sample_generator.sv
// ----------------------------------------------------------------------------
// Sine tone sample generator
// Each accepted word with frame_request set yields one formatted sine sample
// per channel (channel_count, clamped to 1..8), channel 0 first and last set
// on the final one; restart zeroes the frame position before the frame is
// made, and a word without frame_request yields nothing. The front takes a
// word every cycle while its two-entry position queue has room. For each frame
// the back runs one shared bit-serial divider three times (24 steps for position
// mod rate, 38 for the phase modulo, 10 for the table index) before its first
// sample, then sends each channel sample through the output register.
// Configuration registers take writes in any cycle (cfg_ready is always high)
// and must only be changed while no frame is in flight.
// ----------------------------------------------------------------------------
`include "sine_tone_sample_generator_defines.svh"

module sine_tone_sample_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                frame_request,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sts_pkg::SAMPLE_W-1:0]        sample_word,
    output logic [sts_pkg::CHAN_W-1:0]          channel_index,
    output logic                                last
);

    sts_pkg::cfg_t                        cfg_reg;
    sts_pkg::q_stat_t                     q_stat;
    sts_pkg::div_req_t                    div_req;
    sts_pkg::div_rsp_t                    div_rsp;
    logic                                 push;
    logic [sts_pkg::FRAME_COUNT_BITS-1:0] push_pos;
    logic                                 pop;
    logic [sts_pkg::FRAME_COUNT_BITS-1:0] pop_pos;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_rate    <= sts_pkg::RATE_W'(48000);
            cfg_reg.tone_frequency <= sts_pkg::RATE_W'(1000);
            cfg_reg.channel_count  <= sts_pkg::CHCFG_W'(2);
            cfg_reg.sample_format  <= sts_pkg::FMT_S16;
            cfg_reg.big_endian     <= 1'b0;
            cfg_reg.loop_frames    <= sts_pkg::LOOP_W'(48000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sts_pkg::cfg_reg_t'(cfg_index))
                sts_pkg::REG_SAMPLE_RATE:
                    cfg_reg.sample_rate <= cfg_data[sts_pkg::RATE_W-1:0];
                sts_pkg::REG_TONE_FREQUENCY:
                    cfg_reg.tone_frequency <= cfg_data[sts_pkg::RATE_W-1:0];
                sts_pkg::REG_CHANNEL_COUNT:
                    cfg_reg.channel_count <= cfg_data[sts_pkg::CHCFG_W-1:0];
                sts_pkg::REG_SAMPLE_FORMAT:
                    cfg_reg.sample_format <= cfg_data[sts_pkg::FMT_W-1:0];
                sts_pkg::REG_BIG_ENDIAN:
                    cfg_reg.big_endian <= cfg_data[0];
                sts_pkg::REG_LOOP_FRAMES:
                    cfg_reg.loop_frames <= cfg_data[sts_pkg::LOOP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    sts_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_request (frame_request),
        .restart       (restart),
        .loop_frames   (cfg_reg.loop_frames),
        .q_stat        (q_stat),
        .push          (push),
        .push_pos      (push_pos)
    );

    sts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_pos),
        .pop       (pop),
        .pop_data  (pop_pos),
        .stat      (q_stat)
    );

    sts_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    sts_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_stat        (q_stat),
        .pop           (pop),
        .pop_pos       (pop_pos),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_word   (sample_word),
        .channel_index (channel_index),
        .last          (last)
    );

    `STS_ASSERT_NXT(a_frame_continues, out_valid && out_ready && !last,
        out_valid && channel_index == $past(channel_index) + 1'b1,
        "frame broke off before its last channel")

    `STS_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy,
        "divider restarted while busy")

    `STS_ASSERT_IMP(a_pop_not_empty, pop, !q_stat.empty,
        "position queue popped while empty")

endmodule

### test/sine_tone_sample_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sine tone sample generator testbench
// Sends frame request words and register writes to the generator. A scoreboard
// predicts every channel sample from its own sine table, phase and position
// state, then compares each returned word field by field. A directed set of
// settings comes first, then random settings with random word traffic, random
// stalls on both sides, and one long output hold.
// ----------------------------------------------------------------------------

typedef struct {
    logic [sts_pkg::SAMPLE_W-1:0] word;
    logic [sts_pkg::CHAN_W-1:0]   chan;
    logic                         last;
} tone_sample_t;

class tone_scoreboard;
    logic [sts_pkg::RATE_W-1:0]           rate;
    logic [sts_pkg::RATE_W-1:0]           tone;
    logic [sts_pkg::CHCFG_W-1:0]          chans;
    logic [sts_pkg::FMT_W-1:0]            fmt;
    logic                                 swap;
    logic [sts_pkg::LOOP_W-1:0]           loop_len;
    logic [sts_pkg::FRAME_COUNT_BITS-1:0] frame_pos;
    longint unsigned                      quarter_wave [0:sts_pkg::QUARTER_LEN];
    tone_sample_t                         expected_samples [$];
    int unsigned                          errors;

    function new();
        longint unsigned th;
        longint unsigned th2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned q;
        int              k;
        int              n;
        rate      = 48000;
        tone      = 1000;
        chans     = 2;
        fmt       = sts_pkg::FMT_S16;
        swap      = 1'b0;
        loop_len  = 48000;
        frame_pos = '0;
        errors    = 0;
        for (k = 0; k <= sts_pkg::QUARTER_LEN; k++)
        begin
            th   = (sts_pkg::HALF_PI_Q30 * longint'(k)) / sts_pkg::QUARTER_LEN;
            th2  = (th * th) >> 30;
            term = th;
            sum  = th;
            for (n = 1; n <= 10; n++)
            begin
                term = (term * th2) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                sum  = (n % 2 == 1) ? sum - term : sum + term;
            end
            q = (sum + 64'd16384) >> 15;
            quarter_wave[k] = (q > 64'd32767) ? 64'd32767 : q;
        end
    endfunction

    function void write_field(logic [sts_pkg::CFG_IDX_W-1:0] idx,
                              logic [sts_pkg::CFG_DATA_W-1:0] data);
        case (sts_pkg::cfg_reg_t'(idx))
            sts_pkg::REG_SAMPLE_RATE:    rate     = data[sts_pkg::RATE_W-1:0];
            sts_pkg::REG_TONE_FREQUENCY: tone     = data[sts_pkg::RATE_W-1:0];
            sts_pkg::REG_CHANNEL_COUNT:  chans    = data[sts_pkg::CHCFG_W-1:0];
            sts_pkg::REG_SAMPLE_FORMAT:  fmt      = data[sts_pkg::FMT_W-1:0];
            sts_pkg::REG_BIG_ENDIAN:     swap     = data[0];
            sts_pkg::REG_LOOP_FRAMES:    loop_len = data[sts_pkg::LOOP_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] shape_word(logic neg, int unsigned mag);
        longint unsigned biased;
        logic [31:0]     m;
        int unsigned     p;
        int unsigned     t;
        biased = neg ? 32768 - mag : 32768 + mag;
        case (sts_pkg::sample_fmt_t'(fmt))
            sts_pkg::FMT_U8:
                return 32'((biased * 255) >> 16);
            sts_pkg::FMT_S8:
            begin
                m = 32'((mag * 127) >> 15);
                m = neg ? 32'd0 - m : m;
                return m & 32'h0000_00FF;
            end
            sts_pkg::FMT_U16:
            begin
                m = 32'((biased * 65535) >> 16);
                return swap ? {16'd0, m[7:0], m[15:8]} : m;
            end
            sts_pkg::FMT_S16:
            begin
                m = 32'((mag * 32767) >> 15);
                m = (neg ? 32'd0 - m : m) & 32'h0000_FFFF;
                return swap ? {16'd0, m[7:0], m[15:8]} : m;
            end
            sts_pkg::FMT_F32:
            begin
                if (mag == 0)
                    return 32'd0;
                p = 0;
                t = mag;
                while (t > 1)
                begin
                    t = t >> 1;
                    p++;
                end
                m = {neg, 8'(p + 112), 23'(mag << (23 - p))};
                return swap ? {m[7:0], m[15:8], m[23:16], m[31:24]} : m;
            end
            default:
                return 32'd0;
        endcase
    endfunction

    function void note_frame(logic req, logic rst);
        longint unsigned sr;
        longint unsigned ph;
        longint unsigned idx;
        longint unsigned nxt;
        longint unsigned lp;
        int unsigned     quad;
        int unsigned     r;
        int unsigned     mag;
        int unsigned     count;
        int unsigned     c;
        logic            neg;
        logic [31:0]     word;
        tone_sample_t    s;
        if (rst)
            frame_pos = '0;
        if (!req)
            return;
        sr   = (rate == 0) ? 1 : longint'(rate);
        ph   = (longint'(tone) * (longint'(frame_pos) % sr)) % sr;
        idx  = (ph * sts_pkg::SINE_TABLE_DEPTH) / sr;
        quad = int'((idx / sts_pkg::QUARTER_LEN) % 4);
        r    = int'(idx % sts_pkg::QUARTER_LEN);
        mag  = int'((quad % 2 == 1) ? quarter_wave[sts_pkg::QUARTER_LEN - r]
                                    : quarter_wave[r]);
        neg  = (quad >= 2) && (mag != 0);
        word = shape_word(neg, mag);
        if (chans == 0)
            count = 1;
        else if (chans > sts_pkg::MAX_CHANNELS)
            count = sts_pkg::MAX_CHANNELS;
        else
            count = chans;
        for (c = 0; c < count; c++)
        begin
            s.word = word;
            s.chan = sts_pkg::CHAN_W'(c);
            s.last = (c + 1 == count);
            expected_samples.push_back(s);
        end
        lp  = (loop_len == 0) ? 1 : longint'(loop_len);
        nxt = (longint'(frame_pos) + 1) & ((64'd1 << sts_pkg::FRAME_COUNT_BITS) - 1);
        if (nxt >= lp)
            nxt = 0;
        frame_pos = sts_pkg::FRAME_COUNT_BITS'(nxt);
    endfunction

    function void check_sample(logic [31:0] word, logic [2:0] chan, logic last);
        tone_sample_t s;
        if (expected_samples.size() == 0)
        begin
            $error("unexpected sample: sample_word %h channel_index %0d last %0b",
                   word, chan, last);
            errors++;
            return;
        end
        s = expected_samples.pop_front();
        if (word !== s.word)
        begin
            $error("sample_word expected %h actual %h", s.word, word);
            errors++;
        end
        if (chan !== s.chan)
        begin
            $error("channel_index expected %0d actual %0d", s.chan, chan);
            errors++;
        end
        if (last !== s.last)
        begin
            $error("last expected %0b actual %0b", s.last, last);
            errors++;
        end
    endfunction
endclass

module sine_tone_sample_generator_tb;

    localparam logic [sts_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [sts_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int unsigned FMT_SPARE_LO  = 5;
    localparam int unsigned FMT_SPARE_HI  = 7;
    localparam int          SETTLE_CYCLES = 300;
    localparam int          HOLD_CYCLES   = 3000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [sts_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sts_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic                           frame_request;
    logic                           restart;
    logic                           out_valid;
    logic                           out_ready;
    logic [sts_pkg::SAMPLE_W-1:0]   sample_word;
    logic [sts_pkg::CHAN_W-1:0]     channel_index;
    logic                           last;

    tone_scoreboard board;
    bit             idle_on;
    bit             hold_trigger;
    bit             hold_done;

    sine_tone_sample_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_request (frame_request),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_word   (sample_word),
        .channel_index (channel_index),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [sts_pkg::CFG_DATA_W-1:0] noisy(input int unsigned v,
                                                             input int w);
        return (sts_pkg::CFG_DATA_W'($urandom()) << w) | sts_pkg::CFG_DATA_W'(v);
    endfunction

    task automatic offer_frame(input logic req, input logic rst);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        frame_request <= req;
        restart       <= rst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_frame(req, rst);
    endtask

    task automatic write_register(input logic [sts_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sts_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_field(idx, data);
    endtask

    task automatic drain_samples();
        while (board.expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input int unsigned rate, input int unsigned tone,
                                 input int unsigned chans, input int unsigned fmt,
                                 input int unsigned swap, input int unsigned loop_len);
        in_valid <= 1'b0;
        drain_samples();
        write_register(sts_pkg::REG_SAMPLE_RATE, noisy(rate, sts_pkg::RATE_W));
        write_register(sts_pkg::REG_TONE_FREQUENCY, noisy(tone, sts_pkg::RATE_W));
        write_register(sts_pkg::REG_CHANNEL_COUNT, noisy(chans, sts_pkg::CHCFG_W));
        write_register(sts_pkg::REG_SAMPLE_FORMAT, noisy(fmt, sts_pkg::FMT_W));
        write_register(sts_pkg::REG_BIG_ENDIAN, noisy(swap, 1));
        write_register(sts_pkg::REG_LOOP_FRAMES, noisy(loop_len, sts_pkg::LOOP_W));
        write_register(REG_SPARE_LO, sts_pkg::CFG_DATA_W'($urandom()));
        write_register(REG_SPARE_HI, sts_pkg::CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_sample(sample_word, channel_index, last);
    end

    initial
    begin : sink
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_trigger && !hold_done)
            begin
                out_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int          phase_no;
        int          counted;
        int unsigned rate;
        int unsigned tone;
        int unsigned chans;
        int unsigned fmt;
        int unsigned loop_len;
        logic        req;
        logic        rst;

        board         = new();
        idle_on       = 1'b1;
        hold_trigger  = 1'b0;
        hold_done     = 1'b0;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        frame_request <= 1'b0;
        restart       <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, restart with and without a request
        offer_frame(1'b1, 1'b0);
        offer_frame(1'b1, 1'b0);
        offer_frame(1'b0, 1'b0);
        offer_frame(1'b1, 1'b1);
        offer_frame(1'b0, 1'b1);
        offer_frame(1'b1, 1'b0);

        apply_setting(384000, 383999, 8, sts_pkg::FMT_U8, 1, 24'hFF_FFFF);
        offer_frame(1'b1, 1'b0);
        offer_frame(1'b1, 1'b0);

        // zero rate, tone above rate, zero channels
        apply_setting(0, 524287, 0, sts_pkg::FMT_S8, 0, 16);
        offer_frame(1'b1, 1'b0);
        offer_frame(1'b1, 1'b0);

        // clamp channels, zero loop length
        apply_setting(4, 1, 15, sts_pkg::FMT_U16, 1, 0);
        offer_frame(1'b1, 1'b0);
        offer_frame(1'b1, 1'b0);

        // walk all four quadrants
        apply_setting(4, 1, 1, sts_pkg::FMT_S16, 1, 8);
        repeat (5) offer_frame(1'b1, 1'b0);

        // shrink loop below the current position
        apply_setting(4, 1, 2, sts_pkg::FMT_F32, 0, 2);
        repeat (3) offer_frame(1'b1, 1'b0);

        apply_setting(7, 3, 3, sts_pkg::FMT_F32, 1, 100);
        offer_frame(1'b1, 1'b0);
        offer_frame(1'b1, 1'b1);

        apply_setting(9, 2, 4, FMT_SPARE_LO, 1, 50);
        offer_frame(1'b1, 1'b0);
        apply_setting(9, 2, 1, FMT_SPARE_HI, 0, 50);
        offer_frame(1'b1, 1'b0);

        for (phase_no = 0; phase_no < 6; phase_no++)
        begin
            case ($urandom_range(0, 19))
                0:       rate = 0;
                1, 2, 3: rate = $urandom_range(1, 16);
                default: rate = $urandom_range(1, 384000);
            endcase
            if ($urandom_range(0, 3) == 0)
                tone = $urandom_range(0, 524287);
            else
                tone = $urandom_range(0, (rate == 0) ? 0 : rate - 1);
            chans = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(1, sts_pkg::MAX_CHANNELS);
            fmt = ($urandom_range(0, 7) == 0)
                ? $urandom_range(FMT_SPARE_LO, FMT_SPARE_HI)
                : $urandom_range(sts_pkg::FMT_U8, sts_pkg::FMT_F32);
            case ($urandom_range(0, 9))
                0:       loop_len = 0;
                1, 2:    loop_len = $urandom_range(0, 24'hFF_FFFF);
                default: loop_len = $urandom_range(1, 40);
            endcase
            apply_setting(rate, tone, chans, fmt, $urandom_range(0, 1), loop_len);
            idle_on = (phase_no != 5);
            if (phase_no == 1)
                hold_trigger = 1'b1;
            counted = 0;
            while (counted < 50)
            begin
                req = ($urandom_range(0, 9) != 0);
                rst = ($urandom_range(0, 9) == 0);
                offer_frame(req, rst);
                if (req || rst)
                    counted++;
            end
        end

        in_valid <= 1'b0;
        drain_samples();
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule

### filelist.f
+incdir+sv
sv/sts_pkg.sv
sv/sts_queue.sv
sv/sts_front.sv
sv/sts_divider.sv
sv/sts_back.sv
sv/sine_tone_sample_generator.sv
test/sine_tone_sample_generator_tb.sv
